// ===== src/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon test unit.
package pip_pkg;

    // Item kinds carried on the input tuser bit
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_TEST_MODE    = 1'b1;

    // Test modes
    localparam logic MODE_CONVEX  = 1'b0;
    localparam logic MODE_WINDING = 1'b1;

    // Fixed field widths
    localparam int CFG_DATA_W = 7;
    localparam int IDX_W      = 6;
    localparam int OUT_DATA_W = 8;

    // Control that travels down the edge cell chain with each edge
    typedef struct packed {
        logic valid;  // edge present in this cell
        logic last;   // final edge of the query
        logic a_le;   // start y <= py
        logic b_gt;   // end y > py
    } t_edge_ctl;

endpackage

// ===== src/point_in_polygon_test_unit.sv =====
// Top level of the point-in-polygon test unit: vertex memory, sequencer, edge chain.
//
// Input stream (s_axis_*): tuser selects the word kind. A vertex write stores
// (x, y) into slot vertex_index and gives no result. A query tests point (x, y)
// against the first vertex_count stored vertices and gives one output word whose
// bit 0 is the inside flag.
// Config channel (i_cfg_*): index 0 vertex_count, index 1 test_mode (0 convex
// right-side test, 1 winding number test); always ready, write while idle.
// A query reads R vertices through the vertex memory's read port, one per cycle,
// with R = n in convex mode and n + 1 in winding mode (ring closes on vertex 0).
// Each consecutive vertex pair forms an edge that moves down a chain of three
// cells (differences, products, sign) and then into the accumulator.
// A query with edges passes through the read, wait and result states; one with no
// edges goes straight to the result state. Input tready is low while a query is in
// flight, so a new word is accepted only after the result leaves the sequencer.
// The output word sits in a register: a new item is accepted while it waits,
// and a finished query holds until that register is free.
// Reset (synchronous, active low) clears the config registers to 0 and empties
// all stages; the vertex memory is left as is and must be written before use.
module point_in_polygon_test_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 24
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    // stream in
    input  logic                                                 s_axis_tvalid,
    output logic                                                 s_axis_tready,
    // tdata: vertex_index[5:0], coord_x, coord_y, zero fill
    input  logic [((pip_pkg::IDX_W+2*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // tuser: action (0 write vertex, 1 test point)
    input  logic                                                 s_axis_tuser,
    // stream out
    output logic                                                 m_axis_tvalid,
    input  logic                                                 m_axis_tready,
    // tdata: inside_res[0], zero fill
    output logic [pip_pkg::OUT_DATA_W-1:0]                       m_axis_tdata,
    // config write
    input  logic                                                 i_cfg_valid,
    output logic                                                 o_cfg_ready,
    input  logic                                                 i_cfg_index,
    input  logic [pip_pkg::CFG_DATA_W-1:0]                       i_cfg_data
);
    import pip_pkg::*;

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
    localparam int IW   = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int WNW  = $clog2(MAX_VERTICES + 1) + 2;
    localparam int PW   = 2 * (COORD_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_RES  = 2'd3;

    // config registers
    logic [CFG_DATA_W-1:0] r_vertex_count;
    logic                  r_test_mode;

    // sequencer
    logic [1:0]            r_state;
    logic [CW-1:0]         r_k, r_n, r_last_k;
    logic                  r_mode;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic                  r_res;

    // memory and read stage
    logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] r_rd_x, r_rd_y, r_prev_x, r_prev_y;
    logic                  r_rd_vld, r_rd_first, r_rd_last;

    // accumulator
    logic                  r_fail;
    logic signed [WNW-1:0] r_wn;
    logic                  n_fail;
    logic signed [WNW-1:0] n_wn;
    logic                  up, down, final_res;

    // output register
    logic                  r_out_valid, r_out_res;

    // chain signals
    t_edge_ctl                   diff_ctl, prod_ctl, sign_ctl;
    logic signed [COORD_BITS:0]  pa_x, ba_y, pa_y, ba_x;
    logic signed [PW-1:0]        m1, m2;
    logic                        sign_neg, sign_pos;

    // input decode
    logic                          in_acc, q_start, wr_en, zero_edge, out_load;
    logic [IDX_W-1:0]              in_idx;
    logic [IW-1:0]                 idx_ext;
    logic signed [COORD_BITS-1:0]  in_x, in_y;
    logic [CMPW-1:0]               cnt_ext;
    logic [CW-1:0]                 used;
    logic [AW-1:0]                 rd_addr;

    assign in_idx  = s_axis_tdata[IDX_W-1:0];
    assign in_x    = s_axis_tdata[IDX_W +: COORD_BITS];
    assign in_y    = s_axis_tdata[IDX_W+COORD_BITS +: COORD_BITS];
    assign idx_ext = IW'(in_idx);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign q_start = in_acc && (s_axis_tuser == ACT_QUERY);
    assign wr_en   = in_acc && (s_axis_tuser == ACT_WRITE) && (idx_ext < IW'(MAX_VERTICES));

    // vertex count clamped to the table size
    assign cnt_ext   = CMPW'(r_vertex_count);
    assign used      = (cnt_ext > CMPW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(cnt_ext);
    assign zero_edge = (r_test_mode == MODE_CONVEX) ? (used < CW'(2)) : (used == '0);

    // config port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_test_mode    <= MODE_CONVEX;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data;
                CFG_TEST_MODE:    r_test_mode    <= i_cfg_data[0];
            endcase
        end
    end

    // vertex memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[idx_ext[AW-1:0]] <= in_x;
            mem_y[idx_ext[AW-1:0]] <= in_y;
        end
    end

    // ring closes back on vertex 0
    assign rd_addr = (r_k == r_n) ? '0 : r_k[AW-1:0];

    always_ff @(posedge i_clk) begin
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
    end

    // read stage tags and previous vertex
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ST_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_first <= (r_k == '0);
        r_rd_last  <= (r_k == r_last_k);
        if (r_rd_vld) begin
            r_prev_x <= r_rd_x;
            r_prev_y <= r_rd_y;
        end
    end

    // edge cell chain
    pip_diff_cell #(.COORD_BITS(COORD_BITS)) u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_vld && !r_rd_first),
        .i_last  (r_rd_last),
        .i_ax    (r_prev_x),
        .i_ay    (r_prev_y),
        .i_bx    (r_rd_x),
        .i_by    (r_rd_y),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_ctl   (diff_ctl),
        .o_pa_x  (pa_x),
        .o_ba_y  (ba_y),
        .o_pa_y  (pa_y),
        .o_ba_x  (ba_x)
    );

    pip_prod_cell #(.COORD_BITS(COORD_BITS)) u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (diff_ctl),
        .i_pa_x  (pa_x),
        .i_ba_y  (ba_y),
        .i_pa_y  (pa_y),
        .i_ba_x  (ba_x),
        .o_ctl   (prod_ctl),
        .o_m1    (m1),
        .o_m2    (m2)
    );

    pip_sign_cell #(.COORD_BITS(COORD_BITS)) u_sign (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (prod_ctl),
        .i_m1    (m1),
        .i_m2    (m2),
        .o_ctl   (sign_ctl),
        .o_neg   (sign_neg),
        .o_pos   (sign_pos)
    );

    // accumulator: negative product means p is left of the edge
    assign up   = sign_ctl.a_le && sign_ctl.b_gt && sign_neg;
    assign down = !sign_ctl.a_le && !sign_ctl.b_gt && sign_pos;
    assign n_fail = r_fail || sign_neg;

    always_comb begin
        priority if (up) begin
            n_wn = r_wn + WNW'(1);
        end else if (down) begin
            n_wn = r_wn - WNW'(1);
        end else begin
            n_wn = r_wn;
        end
    end

    assign final_res = (r_mode == MODE_WINDING) ? (n_wn != '0) : !n_fail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || q_start) begin
            r_fail <= 1'b0;
            r_wn   <= '0;
        end else if (sign_ctl.valid) begin
            r_fail <= n_fail;
            r_wn   <= n_wn;
        end
    end

    // sequencer
    assign out_load = (r_state == ST_RES) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (q_start) begin
                        r_k     <= '0;
                        r_state <= zero_edge ? ST_RES : ST_READ;
                    end
                end
                ST_READ: begin
                    r_k <= r_k + CW'(1);
                    if (r_k == r_last_k) begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (sign_ctl.valid && sign_ctl.last) begin
                        r_state <= ST_RES;
                    end
                end
                ST_RES: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // query context and result
    always_ff @(posedge i_clk) begin
        if (q_start) begin
            r_px     <= in_x;
            r_py     <= in_y;
            r_mode   <= r_test_mode;
            r_n      <= used;
            r_last_k <= (r_test_mode == MODE_CONVEX) ? used - CW'(1) : used;
            r_res    <= (r_test_mode == MODE_CONVEX);
        end else if ((r_state == ST_WAIT) && sign_ctl.valid && sign_ctl.last) begin
            r_res    <= final_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_res <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_res);

endmodule

// ===== src/pip_diff_cell.sv =====
// Edge cell one: coordinate differences and y-crossing flags for one edge.
module pip_diff_cell #(
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_last,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    output pip_pkg::t_edge_ctl           o_ctl,
    output logic signed [COORD_BITS:0]   o_pa_x,
    output logic signed [COORD_BITS:0]   o_ba_y,
    output logic signed [COORD_BITS:0]   o_pa_y,
    output logic signed [COORD_BITS:0]   o_ba_x
);
    import pip_pkg::*;

    localparam int DW = COORD_BITS + 1;

    t_edge_ctl             r_ctl;
    logic signed [DW-1:0]  r_pa_x, r_ba_y, r_pa_y, r_ba_x;

    // control: valid clears on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.valid <= i_valid;
            r_ctl.last  <= i_last;
            r_ctl.a_le  <= (i_ay <= i_py);
            r_ctl.b_gt  <= (i_by > i_py);
        end
    end

    // exact differences, one bit wider than the coordinates
    always_ff @(posedge i_clk) begin
        r_pa_x <= DW'(i_px) - DW'(i_ax);
        r_ba_y <= DW'(i_by) - DW'(i_ay);
        r_pa_y <= DW'(i_py) - DW'(i_ay);
        r_ba_x <= DW'(i_bx) - DW'(i_ax);
    end

    assign o_ctl  = r_ctl;
    assign o_pa_x = r_pa_x;
    assign o_ba_y = r_ba_y;
    assign o_pa_y = r_pa_y;
    assign o_ba_x = r_ba_x;

endmodule

// ===== src/pip_prod_cell.sv =====
// Edge cell two: the two cross-product terms, one multiplier each.
module pip_prod_cell #(
    parameter int COORD_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pip_pkg::t_edge_ctl               i_ctl,
    input  logic signed [COORD_BITS:0]       i_pa_x,
    input  logic signed [COORD_BITS:0]       i_ba_y,
    input  logic signed [COORD_BITS:0]       i_pa_y,
    input  logic signed [COORD_BITS:0]       i_ba_x,
    output pip_pkg::t_edge_ctl               o_ctl,
    output logic signed [2*COORD_BITS+1:0]   o_m1,
    output logic signed [2*COORD_BITS+1:0]   o_m2
);
    import pip_pkg::*;

    localparam int PW = 2 * (COORD_BITS + 1);

    t_edge_ctl            r_ctl;
    logic signed [PW-1:0] r_m1, r_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // (px-ax)(by-ay) and (py-ay)(bx-ax), exact
    always_ff @(posedge i_clk) begin
        r_m1 <= PW'(i_pa_x) * PW'(i_ba_y);
        r_m2 <= PW'(i_pa_y) * PW'(i_ba_x);
    end

    assign o_ctl = r_ctl;
    assign o_m1  = r_m1;
    assign o_m2  = r_m2;

endmodule

// ===== src/pip_sign_cell.sv =====
// Edge cell three: sign of the cross product difference.
module pip_sign_cell #(
    parameter int COORD_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pip_pkg::t_edge_ctl             i_ctl,
    input  logic signed [2*COORD_BITS+1:0] i_m1,
    input  logic signed [2*COORD_BITS+1:0] i_m2,
    output pip_pkg::t_edge_ctl             o_ctl,
    output logic                           o_neg,
    output logic                           o_pos
);
    import pip_pkg::*;

    localparam int PW = 2 * (COORD_BITS + 1);
    localparam int SW = PW + 1;

    t_edge_ctl            r_ctl;
    logic                 r_neg, r_pos;
    logic signed [SW-1:0] diff;

    // full-width difference, no overflow possible
    assign diff = SW'(i_m1) - SW'(i_m2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= diff[SW-1];
        r_pos <= !diff[SW-1] && (diff != '0);
    end

    assign o_ctl = r_ctl;
    assign o_neg = r_neg;
    assign o_pos = r_pos;

endmodule

// ===== src/pip_checker.sv =====
// Port-level checks for the point-in-polygon test unit, bound to the top level.
module pip_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [pip_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import pip_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // an accepted query keeps the input closed in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_QUERY) |=> !s_axis_tready)
        else $error("input open right after a query");

    // a vertex write leaves the input open
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_WRITE) |=> s_axis_tready)
        else $error("input closed after a vertex write");

    // a new result only appears after a query held the input closed
    a_res_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a query in flight");

    // only the flag bit of the output word is used
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:1] == '0))
        else $error("output fill bits not zero");

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/inside_flag_checker.sv =====
// Channel monitor for the point-in-polygon unit: predicts and checks each inside flag.
`timescale 1ns / 1ps

module inside_flag_checker #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 24,
    parameter int DATA_W       = 56
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [DATA_W-1:0]              s_axis_tdata,
    input  logic                           s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [pip_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [pip_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             mismatch_count,
    output int                             flags_due
);
    import pip_pkg::*;

    // Shadow copy of the vertex table and the two config registers
    longint                vx_shadow [MAX_VERTICES];
    longint                vy_shadow [MAX_VERTICES];
    logic [CFG_DATA_W-1:0] count_shadow;
    logic                  mode_shadow;

    // Inside flags owed by the unit, oldest first
    logic                  in_flags_due [$];

    // Sign of a*b - c*d; coordinates are 24 bits so 64-bit math is exact
    function automatic int turn_sign(longint a, longint b, longint c, longint d);
        longint diff;
        diff = a * b - c * d;
        if (diff < 0)
            return -1;
        return (diff == 0) ? 0 : 1;
    endfunction

    function automatic logic point_in_poly(longint px, longint py);
        int     n;
        int     j;
        int     wn;
        int     s;
        longint ax, ay, bx, by;
        n  = (count_shadow > MAX_VERTICES) ? MAX_VERTICES : int'(count_shadow);
        wn = 0;
        if (mode_shadow == MODE_CONVEX) begin
            // open chain: point must sit right of or on every edge
            for (int i = 0; i + 1 < n; i++) begin
                ax = vx_shadow[i];
                ay = vy_shadow[i];
                bx = vx_shadow[i+1];
                by = vy_shadow[i+1];
                if (turn_sign(px - ax, by - ay, py - ay, bx - ax) < 0)
                    return 1'b0;
            end
            return 1'b1;
        end
        // closed ring, integer winding number
        for (int i = 0; i < n; i++) begin
            j  = (i + 1 == n) ? 0 : i + 1;
            ax = vx_shadow[i];
            ay = vy_shadow[i];
            bx = vx_shadow[j];
            by = vy_shadow[j];
            s  = turn_sign(bx - ax, py - ay, px - ax, by - ay);
            if (ay <= py) begin
                if (by > py && s > 0)
                    wn++;
            end else begin
                if (by <= py && s < 0)
                    wn--;
            end
        end
        return (wn != 0);
    endfunction

    always @(posedge i_clk) begin : watch
        logic [IDX_W-1:0]             slot;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic                         want;
        if (!i_rst_n) begin
            count_shadow = '0;
            mode_shadow  = MODE_CONVEX;
            in_flags_due.delete();
        end else begin
            // result side first: a flag leaving now never belongs to a query entering now
            if (m_axis_tvalid && m_axis_tready) begin
                if (in_flags_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result word, expected none, actual inside=%0d",
                             $time, m_axis_tdata[0]);
                end else begin
                    want = in_flags_due.pop_front();
                    if (m_axis_tdata[0] !== want) begin
                        mismatch_count++;
                        $display("%0t: inside flag mismatch, expected %0d, actual %0d",
                                 $time, want, m_axis_tdata[0]);
                    end
                end
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_VERTEX_COUNT: count_shadow = i_cfg_data;
                    CFG_TEST_MODE:    mode_shadow  = i_cfg_data[0];
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                slot = s_axis_tdata[IDX_W-1:0];
                px   = s_axis_tdata[IDX_W +: COORD_BITS];
                py   = s_axis_tdata[IDX_W+COORD_BITS +: COORD_BITS];
                if (s_axis_tuser == ACT_WRITE) begin
                    if (slot < MAX_VERTICES) begin
                        vx_shadow[slot] = longint'(px);
                        vy_shadow[slot] = longint'(py);
                    end
                end else begin
                    in_flags_due.push_back(point_in_poly(longint'(px), longint'(py)));
                end
            end
        end
        flags_due = in_flags_due.size();
    end

endmodule

// ===== tb/point_in_polygon_test_unit_tb.sv =====
// Stimulus and verdict for the point-in-polygon unit; checking lives in inside_flag_checker.
`timescale 1ns / 1ps

module point_in_polygon_test_unit_tb;
    import pip_pkg::*;

    localparam int  MAX_VERTICES   = 64;
    localparam int  COORD_BITS     = 24;
    localparam int  DATA_W         = ((IDX_W + 2 * COORD_BITS + 7) / 8) * 8;
    localparam int  LATENCY_CYCLES = MAX_VERTICES + 16;
    localparam int  STALL_LIMIT    = 2000;
    localparam int  TARGET_WORDS   = 800;
    localparam int  C_MAX          = (1 << (COORD_BITS - 1)) - 1;
    localparam int  C_MIN          = -(1 << (COORD_BITS - 1));
    localparam real TWO_PI         = 6.283185307179586;

    typedef enum {SHAPE_CW, SHAPE_CCW, SHAPE_STAR, SHAPE_NOISE, SHAPE_FLAT} t_shape;
    typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_MOSTLY, DRAIN_TRICKLE} t_drain;
    typedef enum {AIM_CENTER, AIM_BOX, AIM_VERTEX, AIM_MIDPOINT, AIM_LEVEL, AIM_EXTREME,
                  AIM_ANY} t_aim;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [DATA_W-1:0]     s_axis_tdata  = '0;
    logic                  s_axis_tuser  = ACT_WRITE;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  i_cfg_index   = CFG_VERTEX_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    wire                   s_axis_tready;
    wire                   m_axis_tvalid;
    wire  [OUT_DATA_W-1:0] m_axis_tdata;
    wire                   o_cfg_ready;
    int                    mismatch_count;
    int                    flags_due;

    // Polygon as last written, used to aim queries at vertices and edges
    int poly_x [MAX_VERTICES];
    int poly_y [MAX_VERTICES];
    int ctr_x       = 0;
    int ctr_y       = 0;
    int radius      = 1000;
    int burst_left  = 0;
    int words_sent  = 0;
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    point_in_polygon_test_unit #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    inside_flag_checker #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS),
        .DATA_W      (DATA_W)
    ) flag_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .mismatch_count(mismatch_count),
        .flags_due     (flags_due)
    );

    // Watchdog: any accepted word on any channel restarts the count
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side backpressure: switches to a new random drain style whenever the current one runs out
    always @(negedge i_clk) begin : drain
        t_drain drain_style;
        int     drain_left;
        if (drain_left == 0) begin
            drain_style = t_drain'($urandom_range(0, 3));
            drain_left  = $urandom_range(8, 64);
        end
        drain_left--;
        case (drain_style)
            DRAIN_FREE:   m_axis_tready = 1'b1;
            DRAIN_COIN:   m_axis_tready = 1'($urandom_range(0, 1));
            DRAIN_MOSTLY: m_axis_tready = ($urandom_range(0, 4) != 0);
            default:      m_axis_tready = (drain_left % 12 == 0);
        endcase
    end

    function automatic int any_coord();
        logic signed [COORD_BITS-1:0] v;
        v = COORD_BITS'($urandom);
        return int'(v);
    endfunction

    function automatic int corner_coord();
        case ($urandom_range(0, 3))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    // Send one word; bursts of random length, random gaps between them
    task automatic push_word(input logic act, input int idx, input int x, input int y);
        logic [DATA_W-1:0] word;
        int                gap;
        word = '0;
        word[IDX_W-1:0]                   = idx[IDX_W-1:0];
        word[IDX_W +: COORD_BITS]            = x[COORD_BITS-1:0];
        word[IDX_W+COORD_BITS +: COORD_BITS] = y[COORD_BITS-1:0];
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = word;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic write_vertex(input int slot, input int x, input int y);
        poly_x[slot] = x;
        poly_y[slot] = y;
        push_word(ACT_WRITE, slot, x, y);
    endtask

    task automatic query_point(input int x, input int y);
        push_word(ACT_QUERY, $urandom_range(0, (1 << IDX_W) - 1), x, y);
    endtask

    // Drain everything owed, then let a query that is still walking finish
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (flags_due != 0) @(negedge i_clk);
        repeat (LATENCY_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_up(input int count, input logic mode);
        settle();
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_VERTEX_COUNT, count);
            write_reg(CFG_TEST_MODE, mode);
        end else begin
            write_reg(CFG_TEST_MODE, mode);
            write_reg(CFG_VERTEX_COUNT, count);
        end
    endtask

    // Fill slots 0..n-1 with a polygon of the given shape, plus up to two stray writes to unused slots
    task automatic build_polygon(input int n, input t_shape shape);
        real ang;
        int  x, y, sx, sy;
        ctr_x  = int'($urandom_range(0, 1 << 22)) - (1 << 21);
        ctr_y  = int'($urandom_range(0, 1 << 22)) - (1 << 21);
        radius = ($urandom_range(0, 4) == 0) ? $urandom_range(1 << 20, 6000000)
                                              : $urandom_range(64, 20000);
        sx     = $urandom_range(0, 3);
        sy     = $urandom_range(0, 2);
        for (int k = 0; k < n; k++) begin
            case (shape)
                SHAPE_CW:   ang = -TWO_PI * k / n;
                SHAPE_CCW:  ang = TWO_PI * k / n;
                SHAPE_STAR: ang = -TWO_PI * ((2 * k) % n) / n;
                default:    ang = 0.0;
            endcase
            if (shape == SHAPE_NOISE) begin
                x = any_coord();
                y = any_coord();
            end else if (shape == SHAPE_FLAT) begin
                // collinear or repeated points
                x = ctr_x + k * sx;
                y = ctr_y + k * sy;
            end else begin
                x = ctr_x + $rtoi(radius * $cos(ang));
                y = ctr_y + $rtoi(radius * $sin(ang));
            end
            write_vertex(k, x, y);
        end
        if (n < MAX_VERTICES)
            repeat ($urandom_range(0, 2))
                write_vertex($urandom_range(n, MAX_VERTICES - 1), any_coord(), any_coord());
    endtask

    // One query, aimed at the inside, the boundary, vertex levels or anywhere
    task automatic aim_query(input int n);
        t_aim aim;
        int   i, j, x, y, span;
        aim = t_aim'($urandom_range(0, 6));
        if (n == 0 && (aim == AIM_VERTEX || aim == AIM_MIDPOINT || aim == AIM_LEVEL))
            aim = AIM_BOX;
        i    = (n == 0) ? 0 : $urandom_range(0, n - 1);
        j    = (i + 1 == n) ? 0 : i + 1;
        span = radius + radius / 4 + 1;
        x    = ctr_x + int'($urandom_range(0, 2 * span)) - span;
        y    = ctr_y + int'($urandom_range(0, 2 * span)) - span;
        case (aim)
            AIM_CENTER: begin
                x = ctr_x + int'($urandom_range(0, radius)) - radius / 2;
                y = ctr_y + int'($urandom_range(0, radius)) - radius / 2;
            end
            AIM_VERTEX: begin
                x = poly_x[i];
                y = poly_y[i];
            end
            AIM_MIDPOINT: begin
                x = (poly_x[i] + poly_x[j]) >>> 1;
                y = (poly_y[i] + poly_y[j]) >>> 1;
            end
            AIM_LEVEL:   y = poly_y[i];
            AIM_EXTREME: begin
                x = corner_coord();
                y = corner_coord();
            end
            AIM_ANY: begin
                x = any_coord();
                y = any_coord();
            end
            default: ;
        endcase
        query_point(x, y);
    endtask

    initial begin : stimulus
        int     phase;
        int     geom;
        int     count;
        int     slot;
        int     pick;
        logic   mode;
        t_shape shape;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty chain and empty ring
        query_point(0, 0);
        set_up(0, MODE_WINDING);
        query_point(C_MIN, C_MAX);

        // Square at the coordinate extremes, clockwise
        write_vertex(0, C_MIN, C_MIN);
        write_vertex(1, C_MIN, C_MAX);
        write_vertex(2, C_MAX, C_MAX);
        write_vertex(3, C_MAX, C_MIN);

        // single vertex in both modes
        set_up(1, MODE_WINDING);
        query_point(C_MIN, C_MIN);
        set_up(1, MODE_CONVEX);
        query_point(1, -1);

        set_up(4, MODE_CONVEX);
        query_point(0, 0);
        query_point(C_MAX, C_MIN);
        query_point(C_MIN, C_MAX);

        // winding on the square: center, corners, edge points
        set_up(4, MODE_WINDING);
        query_point(0, 0);
        query_point(C_MIN, C_MIN);
        query_point(C_MAX, C_MAX);
        query_point(0, C_MIN);
        query_point(0, C_MAX);
        query_point(C_MIN, 0);
        query_point(C_MAX, 0);

        // triangle with the long diagonal
        set_up(3, MODE_WINDING);
        query_point(C_MAX, C_MIN);
        query_point(C_MIN + 1, C_MAX - 1);
        write_vertex(MAX_VERTICES - 1, -1, C_MIN);

        // Random phases: polygon, settings, then a run of queries
        phase = 0;
        while (words_sent < TARGET_WORDS) begin
            if (phase == 0) begin
                geom  = MAX_VERTICES;
                count = (1 << CFG_DATA_W) - 1;
                mode  = MODE_WINDING;
                shape = SHAPE_CW;
            end else if (phase == 1) begin
                geom  = MAX_VERTICES;
                count = MAX_VERTICES;
                mode  = MODE_CONVEX;
                shape = SHAPE_CW;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    geom = $urandom_range(0, 1);
                else if (pick < 60)
                    geom = $urandom_range(3, 8);
                else if (pick < 80)
                    geom = ($urandom_range(0, 1) != 0) ? 2 : $urandom_range(9, 16);
                else if (pick < 92)
                    geom = $urandom_range(17, 40);
                else
                    geom = MAX_VERTICES;
                count = geom;
                if (geom == MAX_VERTICES && $urandom_range(0, 1) != 0)
                    count = $urandom_range(MAX_VERTICES + 1, (1 << CFG_DATA_W) - 1);
                mode  = 1'($urandom_range(0, 1));
                shape = t_shape'($urandom_range(0, 4));
                if (mode == MODE_CONVEX && $urandom_range(0, 4) < 3)
                    shape = SHAPE_CW;
            end
            build_polygon(geom, shape);
            set_up(count, mode);
            repeat ($urandom_range(8, 24)) begin
                if ($urandom_range(0, 7) == 0) begin
                    // nudge a live vertex, or scribble on an unused slot
                    slot = $urandom_range(0, MAX_VERTICES - 1);
                    if (slot < geom)
                        write_vertex(slot, poly_x[slot] + int'($urandom_range(0, 16)) - 8,
                                     poly_y[slot] + int'($urandom_range(0, 16)) - 8);
                    else
                        write_vertex(slot, any_coord(), any_coord());
                end else begin
                    aim_query(geom);
                end
            end
            phase++;
        end

        settle();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pip_pkg.sv
src/pip_diff_cell.sv
src/pip_prod_cell.sv
src/pip_sign_cell.sv
src/point_in_polygon_test_unit.sv
src/pip_checker.sv
tb/inside_flag_checker.sv
tb/point_in_polygon_test_unit_tb.sv
